>>> sv/bwcf_pkg.sv
// ----------------------------------------------------------------------------
// bwcf_pkg: shared types and constants of the binary window count filter
// Sizes of the grid, the window and the register file, plus helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bwcf_pkg;

  // grid and window geometry
  localparam int unsigned MAX_COLS    = 1024;
  localparam int unsigned MAX_ROWS    = 1024;
  localparam int unsigned WINDOW_HALF = 2;
  localparam int unsigned WSZ         = 2 * WINDOW_HALF;
  localparam int unsigned WIN_BITS    = WSZ * WSZ;
  localparam int unsigned STORE_W     = WSZ - 1;
  localparam int unsigned LAG         = WINDOW_HALF - 1;
  localparam int unsigned CNT_W       = $clog2(WIN_BITS + 1);
  localparam int unsigned COL_AW      = $clog2(MAX_COLS);
  localparam int unsigned ROW_AW      = $clog2(MAX_ROWS);

  // field widths fixed by the interface
  localparam int unsigned ROW_W    = 10;
  localparam int unsigned COL_W    = 10;
  localparam int unsigned THR_W    = 5;
  localparam int unsigned MARGIN_W = 9;
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned CFG_DW   = 11;
  localparam int unsigned SUM_W    = SIZE_W + 1;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_COUNT_THRESHOLD = 2'd0;
  localparam logic [CFG_AW-1:0] REG_BORDER_MARGIN   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_GRID_ROWS       = 2'd2;
  localparam logic [CFG_AW-1:0] REG_GRID_COLS       = 2'd3;

  // reset values
  localparam logic [THR_W-1:0]    RST_THRESHOLD = 5'd3;
  localparam logic [MARGIN_W-1:0] RST_MARGIN    = 9'd100;
  localparam logic [SIZE_W-1:0]   RST_ROWS      = 11'd1000;
  localparam logic [SIZE_W-1:0]   RST_COLS      = 11'd1000;

  // active configuration, sizes already clamped
  typedef struct packed {
    logic [THR_W-1:0]    threshold;
    logic [MARGIN_W-1:0] margin;
    logic [SIZE_W-1:0]   rows;
    logic [SIZE_W-1:0]   cols;
  } cfg_t;

  // cell position held between the window stage and the decision stage
  typedef struct packed {
    logic [ROW_AW-1:0] row;
    logic [COL_AW-1:0] col;
    logic              last;
  } stage_t;

  // map a size of zero to one and cap it at the maximum
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W:0]   maxv);
    logic [SIZE_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if ({1'b0, v} > maxv) begin
      res = maxv[SIZE_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> sv/bwcf_if.sv
// ----------------------------------------------------------------------------
// bwcf_if: channel interfaces of the binary window count filter
// Input cell channel, result channel and register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface bwcf_in_if;
  logic valid;
  logic ready;
  logic occupied;

  modport source (output valid, output occupied, input ready);
  modport sink   (input valid, input occupied, output ready);
endinterface

interface bwcf_out_if;
  logic                     valid;
  logic                     ready;
  logic                     obstacle;
  logic [bwcf_pkg::ROW_W-1:0] out_row;
  logic [bwcf_pkg::COL_W-1:0] out_col;
  logic                     cell_valid;
  logic                     frame_end;

  modport source (output valid, output obstacle, output out_row, output out_col,
                  output cell_valid, output frame_end, input ready);
  modport sink   (input valid, input obstacle, input out_row, input out_col,
                  input cell_valid, input frame_end, output ready);
endinterface

interface bwcf_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bwcf_pkg::CFG_AW-1:0] index;
  logic [bwcf_pkg::CFG_DW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/bwcf_linebuf.sv
// ----------------------------------------------------------------------------
// bwcf_linebuf: line buffer of the previous rows
// One entry per column, one write and one registered read per cycle, with
// the written value forwarded when both hit the same column.
// ----------------------------------------------------------------------------
`default_nettype none

module bwcf_linebuf (
  input  wire logic                          clk_i,
  input  wire logic                          wr_en_i,
  input  wire logic [bwcf_pkg::COL_AW-1:0]   wr_addr_i,
  input  wire logic [bwcf_pkg::STORE_W-1:0]  wr_data_i,
  input  wire logic [bwcf_pkg::COL_AW-1:0]   rd_addr_i,
  output logic      [bwcf_pkg::STORE_W-1:0]  rd_data_o
);

  logic [bwcf_pkg::STORE_W-1:0] mem [bwcf_pkg::MAX_COLS];
  logic [bwcf_pkg::STORE_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read, forward a same-cycle write
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      rd_data_q <= wr_data_i;
    end else begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> sv/bwcf_front.sv
// ----------------------------------------------------------------------------
// bwcf_front: raster counters, line buffer and sliding window
// Takes one cell per transaction, shifts its column into the window and
// holds the cell position for the decision stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bwcf_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bwcf_pkg::cfg_t     cfg_i,
  input  wire logic               in_valid_i,
  input  wire logic               occupied_i,
  output logic                    in_ready_o,
  input  wire logic               take_i,
  output logic                    stage_valid_o,
  output bwcf_pkg::stage_t        stage_o,
  output logic [bwcf_pkg::WIN_BITS-1:0] window_o
);

  logic [bwcf_pkg::COL_AW-1:0]   col_q, col_d;
  logic [bwcf_pkg::ROW_AW-1:0]   row_q, row_d;
  logic [bwcf_pkg::WIN_BITS-1:0] window_q, window_d;
  logic                          stage_valid_q, stage_valid_d;
  bwcf_pkg::stage_t              stage_q, stage_d;

  logic                          accept;
  logic [bwcf_pkg::STORE_W-1:0]  store_rd;
  logic [bwcf_pkg::WSZ-1:0]      column;
  logic [bwcf_pkg::SIZE_W-1:0]   col_inc, row_inc;
  logic                          col_wrap, row_wrap;
  logic [bwcf_pkg::COL_AW-1:0]   rd_addr;

  assign in_ready_o = !stage_valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  // new column: stored bits of earlier rows with the incoming cell below
  assign column = {store_rd, occupied_i};

  // raster position of the next cell
  assign col_inc  = bwcf_pkg::SIZE_W'(col_q) + bwcf_pkg::SIZE_W'(1);
  assign row_inc  = bwcf_pkg::SIZE_W'(row_q) + bwcf_pkg::SIZE_W'(1);
  assign col_wrap = (col_inc >= cfg_i.cols);
  assign row_wrap = (row_inc >= cfg_i.rows);

  always_comb begin
    col_d         = col_q;
    row_d         = row_q;
    window_d      = window_q;
    stage_valid_d = stage_valid_q;
    stage_d       = stage_q;
    if (take_i) begin
      stage_valid_d = 1'b0;
    end
    if (accept) begin
      window_d      = {window_q[bwcf_pkg::WIN_BITS-bwcf_pkg::WSZ-1:0], column};
      stage_valid_d = 1'b1;
      stage_d.row   = row_q;
      stage_d.col   = col_q;
      stage_d.last  = col_wrap && row_wrap;
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : row_inc[bwcf_pkg::ROW_AW-1:0];
      end else begin
        col_d = col_inc[bwcf_pkg::COL_AW-1:0];
      end
    end
  end

  // prefetch the line buffer entry of the next cell
  assign rd_addr = col_d;

  bwcf_linebuf u_linebuf (
    .clk_i     (clk_i),
    .wr_en_i   (accept),
    .wr_addr_i (col_q),
    .wr_data_i (column[bwcf_pkg::STORE_W-1:0]),
    .rd_addr_i (rd_addr),
    .rd_data_o (store_rd)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q         <= '0;
      row_q         <= '0;
      window_q      <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      col_q         <= col_d;
      row_q         <= row_d;
      window_q      <= window_d;
      stage_valid_q <= stage_valid_d;
    end
  end

  // position payload
  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign stage_valid_o = stage_valid_q;
  assign stage_o       = stage_q;
  assign window_o      = window_q;

endmodule

`default_nettype wire

>>> sv/bwcf_decide.sv
// ----------------------------------------------------------------------------
// bwcf_decide: window vote and result register
// Counts the set cells of the window, checks the interior and registers
// the result for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bwcf_decide (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bwcf_pkg::cfg_t                cfg_i,
  input  wire logic                          stage_valid_i,
  input  wire bwcf_pkg::stage_t              stage_i,
  input  wire logic [bwcf_pkg::WIN_BITS-1:0] window_i,
  output logic                               take_o,
  bwcf_out_if.source                         out_o
);

  logic                         out_valid_q, out_valid_d;
  logic                         obstacle_q, obstacle_d;
  logic [bwcf_pkg::ROW_W-1:0]   row_q, row_d;
  logic [bwcf_pkg::COL_W-1:0]   col_q, col_d;
  logic                         cell_valid_q, cell_valid_d;
  logic                         frame_end_q;

  logic [bwcf_pkg::CNT_W-1:0]    count;
  logic [bwcf_pkg::MARGIN_W-1:0] margin;
  logic [bwcf_pkg::ROW_AW-1:0]   rr;
  logic [bwcf_pkg::COL_AW-1:0]   cc;
  logic [bwcf_pkg::SUM_W-1:0]    rr_end, cc_end;
  logic                          interior;

  assign take_o = stage_valid_i && (!out_valid_q || out_o.ready);

  // count set cells in the window
  always_comb begin
    count = '0;
    for (int i = 0; i < bwcf_pkg::WIN_BITS; i++) begin
      count = count + bwcf_pkg::CNT_W'(window_i[i]);
    end
  end

  // effective margin keeps the window inside the grid
  assign margin = (cfg_i.margin < bwcf_pkg::MARGIN_W'(bwcf_pkg::WINDOW_HALF)) ?
                  bwcf_pkg::MARGIN_W'(bwcf_pkg::WINDOW_HALF) : cfg_i.margin;

  assign rr     = stage_i.row - bwcf_pkg::ROW_AW'(bwcf_pkg::LAG);
  assign cc     = stage_i.col - bwcf_pkg::COL_AW'(bwcf_pkg::LAG);
  assign rr_end = bwcf_pkg::SUM_W'(rr) + bwcf_pkg::SUM_W'(margin);
  assign cc_end = bwcf_pkg::SUM_W'(cc) + bwcf_pkg::SUM_W'(margin);

  assign interior = (bwcf_pkg::SUM_W'(rr) >= bwcf_pkg::SUM_W'(margin)) &&
                    (rr_end < bwcf_pkg::SUM_W'(cfg_i.rows)) &&
                    (bwcf_pkg::SUM_W'(cc) >= bwcf_pkg::SUM_W'(margin)) &&
                    (cc_end < bwcf_pkg::SUM_W'(cfg_i.cols));

  // result of the held cell; no reported cell gives zero fields
  always_comb begin
    cell_valid_d = (stage_i.row >= bwcf_pkg::ROW_AW'(bwcf_pkg::LAG)) &&
                   (stage_i.col >= bwcf_pkg::COL_AW'(bwcf_pkg::LAG));
    obstacle_d   = 1'b0;
    row_d        = '0;
    col_d        = '0;
    if (cell_valid_d) begin
      row_d      = bwcf_pkg::ROW_W'(rr);
      col_d      = bwcf_pkg::COL_W'(cc);
      obstacle_d = interior && (bwcf_pkg::SUM_W'(count) >=
                                bwcf_pkg::SUM_W'(cfg_i.threshold));
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take_o) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // output handshake state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, load on a new cell
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      obstacle_q   <= obstacle_d;
      row_q        <= row_d;
      col_q        <= col_d;
      cell_valid_q <= cell_valid_d;
      frame_end_q  <= stage_i.last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.obstacle   = obstacle_q;
  assign out_o.out_row    = row_q;
  assign out_o.out_col    = col_q;
  assign out_o.cell_valid = cell_valid_q;
  assign out_o.frame_end  = frame_end_q;

endmodule

`default_nettype wire

>>> sv/binary_window_count_filter.sv
// ----------------------------------------------------------------------------
// binary_window_count_filter: 4x4 vote filter over a binary occupancy grid
// Cells arrive in raster order; each one completes the window of the cell
// one row up and one column left, which is marked when enough cells are set and it lies inside the margin.
//
//   channel  dir  handshake       payload
//   in_i     in   valid / ready   occupied
//   out_o    out  valid / ready   obstacle, out_row, out_col, cell_valid,
//                                 frame_end
//   cfg_i    in   valid / ready   index, data (always ready)
//
// One cell per cycle sustained while the output is ready; a cell passes the window stage, then the result register.
// The line buffer read for the next column is issued while the current cell
// is taken, so the registered memory read lies in the loop from cell to cell.
// Reset clears the counters, the window and the channel state; the line
// buffer is not cleared. A stalled output holds its result and one more cell
// waits in the window stage before the input is held off.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_window_count_filter (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bwcf_in_if.sink    in_i,
  bwcf_out_if.source out_o,
  bwcf_cfg_if.sink   cfg_i
);

  logic [bwcf_pkg::THR_W-1:0]    threshold_q;
  logic [bwcf_pkg::MARGIN_W-1:0] margin_q;
  logic [bwcf_pkg::SIZE_W-1:0]   rows_q;
  logic [bwcf_pkg::SIZE_W-1:0]   cols_q;
  bwcf_pkg::cfg_t                cfg;

  logic                          take;
  logic                          stage_valid;
  bwcf_pkg::stage_t              stage;
  logic [bwcf_pkg::WIN_BITS-1:0] window;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= bwcf_pkg::RST_THRESHOLD;
      margin_q    <= bwcf_pkg::RST_MARGIN;
      rows_q      <= bwcf_pkg::RST_ROWS;
      cols_q      <= bwcf_pkg::RST_COLS;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        bwcf_pkg::REG_COUNT_THRESHOLD: threshold_q <= cfg_i.data[bwcf_pkg::THR_W-1:0];
        bwcf_pkg::REG_BORDER_MARGIN:   margin_q    <= cfg_i.data[bwcf_pkg::MARGIN_W-1:0];
        bwcf_pkg::REG_GRID_ROWS:       rows_q      <= cfg_i.data[bwcf_pkg::SIZE_W-1:0];
        bwcf_pkg::REG_GRID_COLS:       cols_q      <= cfg_i.data[bwcf_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the sizes to the grid that fits the buffers
  always_comb begin
    cfg.threshold = threshold_q;
    cfg.margin    = margin_q;
    cfg.rows      = bwcf_pkg::clamp_size(rows_q,
                                         (bwcf_pkg::SIZE_W + 1)'(bwcf_pkg::MAX_ROWS));
    cfg.cols      = bwcf_pkg::clamp_size(cols_q,
                                         (bwcf_pkg::SIZE_W + 1)'(bwcf_pkg::MAX_COLS));
  end

  bwcf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_i.valid),
    .occupied_i    (in_i.occupied),
    .in_ready_o    (in_i.ready),
    .take_i        (take),
    .stage_valid_o (stage_valid),
    .stage_o       (stage),
    .window_o      (window)
  );

  bwcf_decide u_decide (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .stage_valid_i (stage_valid),
    .stage_i       (stage),
    .window_i      (window),
    .take_o        (take),
    .out_o         (out_o)
  );

endmodule

`default_nettype wire

>>> sim/binary_window_count_filter_tb.sv
// ----------------------------------------------------------------------------
// binary_window_count_filter_tb: self-checking bench for the 4x4 vote filter
// Streams occupancy cells through the filter under random valid and ready
// gaps and compares every result transaction with a cycle-free model of the
// line buffer, the sliding window and the raster counters kept in the bench.
// ----------------------------------------------------------------------------
module binary_window_count_filter_tb;
  import bwcf_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned RANDOM_CELLS = 1350;

  typedef struct packed {
    logic             obstacle;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             cell_valid;
    logic             frame_end;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst_n;

  bwcf_in_if  in_if ();
  bwcf_out_if out_if ();
  bwcf_cfg_if cfg_if ();

  binary_window_count_filter dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #4 clk = ~clk;

  // model state: registers, line buffer, window and raster position
  logic [THR_W-1:0]    threshold_q = RST_THRESHOLD;
  logic [MARGIN_W-1:0] margin_q    = RST_MARGIN;
  logic [SIZE_W-1:0]   rows_q      = RST_ROWS;
  logic [SIZE_W-1:0]   cols_q      = RST_COLS;
  logic [STORE_W-1:0]  line_bits [MAX_COLS] = '{default: '0};
  int unsigned         line_depth [MAX_COLS];   // writes seen per column, capped at STORE_W
  logic [WIN_BITS-1:0] window_q    = '0;
  logic [ROW_AW-1:0]   row_cnt     = '0;
  logic [COL_AW-1:0]   col_cnt     = '0;

  cell_result_t pending_decisions [$];
  int unsigned  error_count   = 0;
  int unsigned  cycle_count   = 0;
  int unsigned  src_gap_pct   = 0;
  int unsigned  sink_stall_pct = 0;
  int unsigned  sink_hold     = 0;
  int unsigned  hold_off_req  = 0;

  // size register as the block uses it: zero acts as one, capped at the maximum
  function automatic int unsigned grid_extent(input logic [SIZE_W-1:0] value,
                                              input int unsigned cap);
    if (value == '0) return 1;
    return (value > cap) ? cap : int'(value);
  endfunction

  // shift one cell into the window and decide the cell up and to the left
  function automatic cell_result_t decide_cell(input logic occ);
    cell_result_t res;
    int unsigned n_rows, n_cols, margin_eff, r, c, rr, cc;
    logic [WSZ-1:0] column;
    n_rows     = grid_extent(rows_q, MAX_ROWS);
    n_cols     = grid_extent(cols_q, MAX_COLS);
    margin_eff = (margin_q < WINDOW_HALF) ? WINDOW_HALF : int'(margin_q);
    r = row_cnt;
    c = col_cnt;
    column = {line_bits[c], occ};
    line_bits[c] = column[STORE_W-1:0];
    if (line_depth[c] < STORE_W) line_depth[c]++;
    window_q = {window_q[WIN_BITS-WSZ-1:0], column};
    res = '0;
    if (r >= LAG && c >= LAG) begin
      rr = r - LAG;
      cc = c - LAG;
      res.cell_valid = 1'b1;
      res.out_row    = ROW_W'(rr);
      res.out_col    = COL_W'(cc);
      if (rr >= margin_eff && rr + margin_eff < n_rows &&
          cc >= margin_eff && cc + margin_eff < n_cols) begin
        res.obstacle = ($countones(window_q) >= threshold_q);
      end
    end
    res.frame_end = (r + 1 >= n_rows) && (c + 1 >= n_cols);
    // advance the raster position, wrapping on the current sizes
    if (c + 1 >= n_cols) begin
      col_cnt = '0;
      row_cnt = (r + 1 >= n_rows) ? '0 : ROW_AW'(r + 1);
    end else begin
      col_cnt = COL_AW'(c + 1);
    end
    return res;
  endfunction

  // a new width is allowed only if no interior window can pick up a line
  // buffer entry that has not been written enough times
  function automatic bit cols_write_safe(input logic [SIZE_W-1:0] value);
    int unsigned n, rd;
    n = grid_extent(value, MAX_COLS);
    for (int unsigned c = 0; c < n; c++) begin
      rd = (c >= col_cnt && col_cnt < n) ? int'(row_cnt) : int'(row_cnt) + 1;
      if (line_depth[c] < ((rd < STORE_W) ? rd : STORE_W)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned idle_len(input int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return CFG_DW'($urandom_range(0, 3));
      1:       return ($urandom_range(0, 1) == 1) ? CFG_DW'(MAX_ROWS)
                                                  : CFG_DW'($urandom_range(1025, 2047));
      default: return CFG_DW'($urandom_range(4, 14));
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] expv,
                                      input logic [15:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      error_count++;
    end
  endfunction

  // track register writes, predict each accepted cell, check each result
  always @(posedge clk) begin : track_transactions
    cell_result_t want;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_COUNT_THRESHOLD: threshold_q = cfg_if.data[THR_W-1:0];
          REG_BORDER_MARGIN:   margin_q    = cfg_if.data[MARGIN_W-1:0];
          REG_GRID_ROWS:       rows_q      = cfg_if.data[SIZE_W-1:0];
          REG_GRID_COLS:       cols_q      = cfg_if.data[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        pending_decisions.push_back(decide_cell(in_if.occupied));
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_decisions.size() == 0) begin
          $error("result transaction with no cell pending");
          error_count++;
        end else begin
          want = pending_decisions.pop_front();
          check_field("obstacle",   16'(want.obstacle),   16'(out_if.obstacle));
          check_field("out_row",    16'(want.out_row),    16'(out_if.out_row));
          check_field("out_col",    16'(want.out_col),    16'(out_if.out_col));
          check_field("cell_valid", 16'(want.cell_valid), 16'(out_if.cell_valid));
          check_field("frame_end",  16'(want.frame_end),  16'(out_if.frame_end));
        end
      end
    end
  end

  // drive ready: random stalls, or a long hold-off when a test asks for one
  always @(negedge clk) begin
    if (hold_off_req != 0) begin
      sink_hold    = hold_off_req;
      hold_off_req = 0;
    end else if (sink_hold == 0) begin
      sink_hold = idle_len(sink_stall_pct);
    end
    if (sink_hold != 0) begin
      out_if.ready <= 1'b0;
      sink_hold--;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // offer one cell, hold it until accepted; enter and leave on a falling edge
  task automatic send_cell(input logic occ);
    int unsigned gap;
    gap = idle_len(src_gap_pct);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.occupied <= occ;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop offering cells and wait until every result has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_decisions.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // row 0 after reset: no result is a valid cell yet
  task automatic test_defaults();
    repeat (4) send_cell(1'b1);
    wait_drained();
  endtask

  // shrink the grid mid-row to 5x5 with a margin below the window half and
  // threshold zero: the single interior cell is marked though every cell sent is clear
  task automatic test_zero_threshold();
    write_reg(REG_BORDER_MARGIN, '0);
    write_reg(REG_GRID_ROWS, CFG_DW'(5));
    write_reg(REG_GRID_COLS, CFG_DW'(5));
    write_reg(REG_COUNT_THRESHOLD, '0);
    repeat (21) send_cell(1'b0);
    wait_drained();
  endtask

  // a threshold above the window area never marks, even on a full grid;
  // the unused upper data bits are set
  task automatic test_threshold_above_area();
    write_reg(REG_COUNT_THRESHOLD, 11'h7F1);
    write_reg(REG_BORDER_MARGIN, CFG_DW'(1));
    repeat (25) send_cell(1'b1);
    wait_drained();
  endtask

  // sizes of zero and beyond the maximum, changed mid-frame
  task automatic test_clamped_sizes();
    write_reg(REG_GRID_ROWS, '0);
    write_reg(REG_GRID_COLS, 11'd2047);
    send_cell(1'b1);
    send_cell(1'b0);
    send_cell(1'b1);
    wait_drained();
    write_reg(REG_GRID_ROWS, 11'd2047);
    write_reg(REG_GRID_COLS, '0);
    repeat (3) send_cell(1'b1);
    wait_drained();
    write_reg(REG_GRID_ROWS, '0);
    send_cell(1'b0);
    wait_drained();
  endtask

  // hold the result side for a long stretch while cells keep coming
  task automatic test_backpressure();
    write_reg(REG_COUNT_THRESHOLD, CFG_DW'(4));
    write_reg(REG_BORDER_MARGIN, CFG_DW'(2));
    write_reg(REG_GRID_ROWS, CFG_DW'(8));
    write_reg(REG_GRID_COLS, CFG_DW'(8));
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    hold_off_req   = 300;
    repeat (60) send_cell(1'($urandom_range(0, 1)));
    wait_drained();
  endtask

  // pick new register values between phases; widths that could expose an
  // unwritten line buffer entry are skipped
  task automatic shuffle_settings();
    logic [CFG_DW-1:0] value;
    if ($urandom_range(0, 1) == 1) begin
      value = CFG_DW'($urandom_range(0, 2047));
      case ($urandom_range(0, 5))
        0:       value[THR_W-1:0] = '0;
        1:       value[THR_W-1:0] = THR_W'(WIN_BITS);
        2:       value[THR_W-1:0] = THR_W'($urandom_range(WIN_BITS + 1, 31));
        default: value[THR_W-1:0] = THR_W'($urandom_range(1, 10));
      endcase
      if ($urandom_range(0, 3) != 0) value[CFG_DW-1:THR_W] = '0;
      write_reg(REG_COUNT_THRESHOLD, value);
    end
    if ($urandom_range(0, 1) == 1) begin
      value = CFG_DW'($urandom_range(0, 2047));
      case ($urandom_range(0, 7))
        0:       value[MARGIN_W-1:0] = '1;
        1:       value[MARGIN_W-1:0] = MARGIN_W'($urandom_range(0, 511));
        default: value[MARGIN_W-1:0] = MARGIN_W'($urandom_range(0, 3));
      endcase
      if ($urandom_range(0, 3) != 0) value[CFG_DW-1:MARGIN_W] = '0;
      write_reg(REG_BORDER_MARGIN, value);
    end
    if ($urandom_range(0, 1) == 1) write_reg(REG_GRID_ROWS, pick_size());
    if ($urandom_range(0, 1) == 1) begin
      value = pick_size();
      if (cols_write_safe(value)) write_reg(REG_GRID_COLS, value);
    end
  endtask

  // random phases: new settings, density and idling, then a burst of cells
  task automatic test_random_frames();
    int unsigned sent, burst, density, frame, pause_at;
    sent = 0;
    while (sent < RANDOM_CELLS) begin
      shuffle_settings();
      src_gap_pct    = pick_idle_pct();
      sink_stall_pct = pick_idle_pct();
      case ($urandom_range(0, 4))
        0:       density = 0;
        1:       density = 100;
        default: density = $urandom_range(0, 100);
      endcase
      frame = grid_extent(rows_q, MAX_ROWS) * grid_extent(cols_q, MAX_COLS);
      burst = (frame <= 150) ? $urandom_range(8, 2 * frame + 8) : $urandom_range(20, 60);
      pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, burst) : 0;
      for (int unsigned k = 0; k < burst; k++) begin
        if (pause_at != 0 && k == pause_at) wait_drained();
        send_cell($urandom_range(0, 99) < density);
      end
      sent += burst;
      wait_drained();
    end
  endtask

  initial begin
    in_if.valid     = 1'b0;
    in_if.occupied  = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    out_if.ready    = 1'b0;
    rst_n           = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_defaults();
    test_zero_threshold();
    test_threshold_above_area();
    test_clamped_sizes();
    test_backpressure();
    test_random_frames();

    wait_drained();
    repeat (8) @(negedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
